/* rtl/mcs_pkg.sv */
// shared types, constants and helpers for the mhd cfl signal speed block
`timescale 1ns / 1ps
`default_nettype none
package mcs_pkg;

    localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

    typedef struct packed {
        logic signed [31:0] density;
        logic signed [31:0] momentum_x;
        logic signed [31:0] momentum_y;
        logic signed [31:0] momentum_z;
        logic signed [31:0] energy;
        logic signed [31:0] field_x;
        logic signed [31:0] field_y;
        logic signed [31:0] field_z;
        logic               last_cell;
    } t_cell_beat;

    typedef struct packed {
        logic [31:0] inverse_speed;
        logic [31:0] max_speed;
        logic        divide_error;
    } t_result_beat;

    // operations of the arithmetic sequence, in issue order; OP_N9 runs on the separate divide-by-nine sequence
    typedef enum logic [2:0] {
        OP_VX  = 3'd0,
        OP_VY  = 3'd1,
        OP_VZ  = 3'd2,
        OP_K   = 3'd3,
        OP_N9  = 3'd4,
        OP_T   = 3'd5,
        OP_R   = 3'd6,
        OP_INV = 3'd7
    } t_op;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SQ    = 8'b0000_0010,
        S_START = 8'b0000_0100,
        S_RUN   = 8'b0000_1000,
        S_NUM   = 8'b0001_0000,
        S_SPEED = 8'b0010_0000,
        S_CHK   = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    localparam logic [2:0] SQ_LAST = 3'd5;

    typedef struct packed {
        logic       load;
        logic       sq_step;
        logic [2:0] sq_idx;
        logic       start;
        t_op        op;
        logic       num_calc;
        logic       speed_upd;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic arith_done;
        logic rho_zero;
        logic last;
        logic err;
        logic out_busy;
    } t_status;

    function automatic logic [31:0] f_mag(input logic [31:0] x);
        return x[31] ? (~x + 32'd1) : x;
    endfunction

endpackage
`default_nettype wire

/* rtl/mcs_if.sv */
// valid / ready channel interfaces for cell beats and result beats
`timescale 1ns / 1ps
`default_nettype none
interface mcs_cell_if;
    logic                valid;
    logic                ready;
    mcs_pkg::t_cell_beat payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface mcs_result_if;
    logic                  valid;
    logic                  ready;
    mcs_pkg::t_result_beat payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* rtl/mcs_divsqrt.sv */
// shared radix-2 restoring divider and bit-pair square root unit
`timescale 1ns / 1ps
`default_nettype none
module mcs_divsqrt (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic        i_sqrt,
    input  wire logic [63:0] i_dividend,
    input  wire logic [32:0] i_divisor,
    input  wire logic [6:0]  i_steps,
    output logic      [63:0] o_result,
    output logic             o_done,
    output logic             o_busy
);
    logic [63:0] r_x;
    logic [35:0] r_rem;
    logic [31:0] r_root;
    logic [32:0] r_dsr;
    logic        r_sqrt;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    logic [33:0] t_div;
    logic        ge_div;
    logic [35:0] t_sq;
    logic [35:0] trial;
    logic        ge_sq;

    always_comb begin
        t_div  = {r_rem[32:0], r_x[63]};
        ge_div = t_div >= {1'b0, r_dsr};
        t_sq   = {r_rem[33:0], r_x[63:62]};
        trial  = {2'b00, r_root, 2'b01};
        ge_sq  = t_sq >= trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= i_dividend;
            r_rem  <= '0;
            r_root <= '0;
            r_dsr  <= i_divisor;
            r_sqrt <= i_sqrt;
        end else if (r_busy) begin
            if (r_sqrt) begin
                r_rem  <= ge_sq ? (t_sq - trial) : t_sq;
                r_root <= {r_root[30:0], ge_sq};
                r_x    <= {r_x[61:0], 2'b00};
            end else begin
                r_rem <= {2'b00, (ge_div ? (t_div - {1'b0, r_dsr}) : t_div)};
                r_x   <= {r_x[62:0], ge_div};
            end
        end
    end

    assign o_result = r_sqrt ? {32'd0, r_root} : r_x;
    assign o_done   = r_done;
    assign o_busy   = r_busy;

endmodule
`default_nettype wire

/* rtl/mcs_datapath.sv */
// cell registers, squares, pressure numerator, running maximum and result register
`timescale 1ns / 1ps
`default_nettype none
module mcs_datapath (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire mcs_pkg::t_cmd         i_cmd,
    input  wire mcs_pkg::t_cell_beat   i_cell,
    input  wire logic                  i_result_ready,
    output mcs_pkg::t_status           o_status,
    output mcs_pkg::t_result_beat      o_result,
    output logic                       o_result_valid
);
    localparam logic signed [65:0] DIFF_LIM = 66'sh100000000000000;
    localparam logic signed [65:0] DIFF_NEG = -DIFF_LIM;
    localparam logic [2:0]         N9_LAST  = 3'd6;

    logic [31:0]        r_mag [0:5];
    logic [31:0]        r_arho;
    logic               r_rho_neg;
    logic               r_rho_zero;
    logic [31:0]        r_energy;
    logic               r_last;
    logic [63:0]        r_sm;
    logic [63:0]        r_sb;
    logic [31:0]        r_v;
    logic [63:0]        r_kmag;
    logic [61:0]        r_nmag;
    logic [46:0]        r_anum;
    logic [47:0]        r_term;
    logic [31:0]        r_root;
    logic [31:0]        r_inv;
    logic [31:0]        r_max;
    logic               r_sticky;
    mcs_pkg::t_op       r_op;
    mcs_pkg::t_result_beat r_out;
    logic               r_out_valid;
    logic [2:0]         r_n9_cnt;
    logic               r_n9_busy;
    logic               r_n9_done;
    logic [61:0]        r_q9;
    logic signed [63:0] r_r9;

    logic [63:0] a_dividend;
    logic [32:0] a_divisor;
    logic [6:0]  a_steps;
    logic        a_sqrt;
    logic [63:0] a_result;
    logic        a_done;
    logic        a_busy;
    logic        a_start;
    logic        n9_go;
    logic [61:0] q9_fix;

    logic [63:0]        prod;
    logic signed [65:0] k_s;
    logic signed [65:0] d_full;
    logic [57:0]        d_sat;
    logic [62:0]        d63;
    logic [62:0]        sbh63;
    logic [62:0]        num;
    logic [62:0]        nmag;
    logic [32:0]        sum;
    logic [31:0]        speed;
    logic [31:0]        vq;
    logic               err;

    always_comb begin
        a_sqrt     = 1'b0;
        a_divisor  = {1'b0, r_arho};
        a_dividend = {r_mag[0], 32'd0};
        a_steps    = 7'd48;
        case (i_cmd.op)
            mcs_pkg::OP_VX: a_dividend = {r_mag[0], 32'd0};
            mcs_pkg::OP_VY: a_dividend = {r_mag[1], 32'd0};
            mcs_pkg::OP_VZ: a_dividend = {r_mag[2], 32'd0};
            mcs_pkg::OP_K: begin
                a_dividend = r_sm;
                a_divisor  = {r_arho, 1'b0};
                a_steps    = 7'd64;
            end
            mcs_pkg::OP_T: begin
                a_dividend = {r_anum, 17'd0};
                a_steps    = 7'd63;
            end
            mcs_pkg::OP_R: begin
                a_dividend = {r_term, 16'd0};
                a_sqrt     = 1'b1;
                a_steps    = 7'd32;
            end
            mcs_pkg::OP_INV: begin
                a_dividend = {1'b1, 63'd0};
                a_divisor  = {1'b0, r_max};
                a_steps    = 7'd33;
            end
            default: a_steps = 7'd48;
        endcase
    end

    // the divide by nine runs on its own shift-add sequence, not the shared unit
    always_comb begin
        a_start = i_cmd.start && (i_cmd.op != mcs_pkg::OP_N9);
        n9_go   = i_cmd.start && (i_cmd.op == mcs_pkg::OP_N9);
        // estimate is off by at most one either way
        if (r_r9 < 64'sd0) begin
            q9_fix = r_q9 - 62'd1;
        end else if (r_r9 >= 64'sd9) begin
            q9_fix = r_q9 + 62'd1;
        end else begin
            q9_fix = r_q9;
        end
    end

    mcs_divsqrt u_divsqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (a_start),
        .i_sqrt     (a_sqrt),
        .i_dividend (a_dividend),
        .i_divisor  (a_divisor),
        .i_steps    (a_steps),
        .o_result   (a_result),
        .o_done     (a_done),
        .o_busy     (a_busy)
    );

    always_comb begin
        prod   = {32'd0, r_mag[i_cmd.sq_idx]} * {32'd0, r_mag[i_cmd.sq_idx]};
        k_s    = r_rho_neg ? -$signed({2'b00, r_kmag}) : $signed({2'b00, r_kmag});
        d_full = $signed({{34{r_energy[31]}}, r_energy}) - k_s;
        if (d_full > DIFF_LIM) begin
            d_sat = DIFF_LIM[57:0];
        end else if (d_full < DIFF_NEG) begin
            d_sat = DIFF_NEG[57:0];
        end else begin
            d_sat = d_full[57:0];
        end
        // 10*d + 13*(sb >> 16), both by shift and add
        d63   = {{5{d_sat[57]}}, d_sat};
        sbh63 = {15'd0, r_sb[63:16]};
        num   = (d63 << 3) + (d63 << 1) + (sbh63 << 3) + (sbh63 << 2) + sbh63;
        nmag  = num[62] ? (~num + 63'd1) : num;
        sum   = {1'b0, r_v} + {1'b0, r_root};
        if (r_rho_zero) begin
            speed = mcs_pkg::SAT32;
        end else if (sum[32]) begin
            speed = mcs_pkg::SAT32;
        end else begin
            speed = sum[31:0];
        end
        vq  = (|a_result[47:32]) ? mcs_pkg::SAT32 : a_result[31:0];
        err = r_sticky || (r_max == 32'd0);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mag[0]   <= mcs_pkg::f_mag(i_cell.momentum_x);
            r_mag[1]   <= mcs_pkg::f_mag(i_cell.momentum_y);
            r_mag[2]   <= mcs_pkg::f_mag(i_cell.momentum_z);
            r_mag[3]   <= mcs_pkg::f_mag(i_cell.field_x);
            r_mag[4]   <= mcs_pkg::f_mag(i_cell.field_y);
            r_mag[5]   <= mcs_pkg::f_mag(i_cell.field_z);
            r_arho     <= mcs_pkg::f_mag(i_cell.density);
            r_rho_neg  <= i_cell.density[31];
            r_rho_zero <= (i_cell.density == 32'sd0);
            r_energy   <= i_cell.energy;
            r_last     <= i_cell.last_cell;
            r_sm       <= '0;
            r_sb       <= '0;
            r_v        <= '0;
        end
        if (i_cmd.sq_step) begin
            if (i_cmd.sq_idx < 3'd3) begin
                r_sm <= r_sm + prod;
            end else begin
                r_sb <= r_sb + prod;
            end
        end
        if (i_cmd.num_calc) begin
            r_nmag <= nmag[61:0];
        end
        // x/9 as (x - x/8) * (1 + 2^-6)(1 + 2^-12)(1 + 2^-24)(1 + 2^-48) / 8
        if (n9_go) begin
            r_q9 <= r_nmag - (r_nmag >> 3);
        end else if (r_n9_busy) begin
            case (r_n9_cnt)
                3'd0: r_q9 <= r_q9 + (r_q9 >> 6);
                3'd1: r_q9 <= r_q9 + (r_q9 >> 12);
                3'd2: r_q9 <= r_q9 + (r_q9 >> 24);
                3'd3: r_q9 <= r_q9 + (r_q9 >> 48);
                3'd4: r_q9 <= r_q9 >> 3;
                3'd5: begin
                    r_r9 <= $signed({2'b00, r_nmag} - {r_q9[60:0], 3'b000} - {2'b00, r_q9});
                end
                3'd6: r_anum <= (|q9_fix[61:47]) ? '1 : q9_fix[46:0];
                default: ;
            endcase
        end
        if (i_cmd.start) begin
            r_op <= i_cmd.op;
        end
        if (a_done) begin
            case (r_op)
                mcs_pkg::OP_VX, mcs_pkg::OP_VY, mcs_pkg::OP_VZ: begin
                    if (vq > r_v) begin
                        r_v <= vq;
                    end
                end
                mcs_pkg::OP_K:  r_kmag <= a_result;
                mcs_pkg::OP_T:  r_term <= (|a_result[63:48]) ? '1 : a_result[47:0];
                mcs_pkg::OP_R:  r_root <= a_result[31:0];
                mcs_pkg::OP_INV: begin
                    r_inv <= (|a_result[63:32]) ? mcs_pkg::SAT32 : a_result[31:0];
                end
                default: r_root <= a_result[31:0];
            endcase
        end
        if (i_cmd.out_load) begin
            r_out.inverse_speed <= err ? mcs_pkg::SAT32 : r_inv;
            r_out.max_speed     <= r_max;
            r_out.divide_error  <= err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n9_busy <= 1'b0;
            r_n9_done <= 1'b0;
            r_n9_cnt  <= '0;
        end else begin
            r_n9_done <= 1'b0;
            if (n9_go) begin
                r_n9_busy <= 1'b1;
                r_n9_cnt  <= '0;
            end else if (r_n9_busy) begin
                r_n9_cnt <= r_n9_cnt + 3'd1;
                if (r_n9_cnt == N9_LAST) begin
                    r_n9_busy <= 1'b0;
                    r_n9_done <= 1'b1;
                end
            end
        end
    end

    // running maximum, sticky error and result beat control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max       <= '0;
            r_sticky    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.speed_upd) begin
                if (speed > r_max) begin
                    r_max <= speed;
                end
                if (r_rho_zero) begin
                    r_sticky <= 1'b1;
                end
            end
            if (i_cmd.out_load) begin
                r_max       <= '0;
                r_sticky    <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (i_result_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_status.arith_done = a_done || r_n9_done;
        o_status.rho_zero   = r_rho_zero;
        o_status.last       = r_last;
        o_status.err        = err;
        o_status.out_busy   = r_out_valid;
    end

    assign o_result       = r_out;
    assign o_result_valid = r_out_valid;

    a_sticky_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sticky |-> (r_max == mcs_pkg::SAT32))
        else $error("sticky error without saturated maximum");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> !r_out_valid)
        else $error("result register overwritten while pending");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |-> !a_busy)
        else $error("arith unit started while busy");

    a_div9_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n9_go |-> !r_n9_busy)
        else $error("divide by nine started while busy");

endmodule
`default_nettype wire

/* rtl/mcs_ctrl.sv */
// sequencing state machine for one cell through the shared arithmetic unit
`timescale 1ns / 1ps
`default_nettype none
module mcs_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire mcs_pkg::t_status i_status,
    output logic                  o_in_ready,
    output mcs_pkg::t_cmd         o_cmd
);
    mcs_pkg::t_state r_state, n_state;
    mcs_pkg::t_op    r_op, n_op;
    logic [2:0]      r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.op     = r_op;
        o_cmd.sq_idx = r_cnt;
        o_in_ready   = 1'b0;
        unique case (r_state)
            mcs_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = mcs_pkg::S_SQ;
                end
            end
            mcs_pkg::S_SQ: begin
                o_cmd.sq_step = 1'b1;
                if (r_cnt == mcs_pkg::SQ_LAST) begin
                    n_op    = mcs_pkg::OP_VX;
                    n_state = i_status.rho_zero ? mcs_pkg::S_SPEED : mcs_pkg::S_START;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            mcs_pkg::S_START: begin
                o_cmd.start = 1'b1;
                n_state     = mcs_pkg::S_RUN;
            end
            mcs_pkg::S_RUN: begin
                if (i_status.arith_done) begin
                    case (r_op)
                        mcs_pkg::OP_K:   n_state = mcs_pkg::S_NUM;
                        mcs_pkg::OP_R:   n_state = mcs_pkg::S_SPEED;
                        mcs_pkg::OP_INV: n_state = mcs_pkg::S_OUT;
                        default: begin
                            n_op    = mcs_pkg::t_op'(r_op + 3'd1);
                            n_state = mcs_pkg::S_START;
                        end
                    endcase
                end
            end
            mcs_pkg::S_NUM: begin
                o_cmd.num_calc = 1'b1;
                n_op           = mcs_pkg::OP_N9;
                n_state        = mcs_pkg::S_START;
            end
            mcs_pkg::S_SPEED: begin
                o_cmd.speed_upd = 1'b1;
                n_state = i_status.last ? mcs_pkg::S_CHK : mcs_pkg::S_IDLE;
            end
            mcs_pkg::S_CHK: begin
                if (i_status.err) begin
                    n_state = mcs_pkg::S_OUT;
                end else begin
                    n_op    = mcs_pkg::OP_INV;
                    n_state = mcs_pkg::S_START;
                end
            end
            mcs_pkg::S_OUT: begin
                if (!i_status.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = mcs_pkg::S_IDLE;
                end
            end
            default: n_state = mcs_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mcs_pkg::S_IDLE;
            r_op    <= mcs_pkg::OP_VX;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_cnt   <= n_cnt;
        end
    end

endmodule
`default_nettype wire

/* rtl/mhd_cfl_max_signal_speed.sv */
// a last cell adds the reciprocal divide unless an error is flagged; zero density skips all divides and the root
// throughput: one cell at a time, set by the shared radix-2 divider and square root:
//   three 48-step velocity divides, 64- and 63-step divides and a 32-step root,
//   plus a seven-step shift-add divide by nine
// a pending result beat does not block the next cell; only a further last cell waits
// reset: synchronous active-low i_rst_n clears running maximum, error flag and control
`timescale 1ns / 1ps
`default_nettype none
module mhd_cfl_max_signal_speed (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    mcs_cell_if.sink    i_cell,
    mcs_result_if.source o_result
);
    mcs_pkg::t_cmd    cmd;
    mcs_pkg::t_status status;
    logic             in_ready;

    mcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cell.valid),
        .i_status   (status),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    mcs_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_cell         (i_cell.payload),
        .i_result_ready (o_result.ready),
        .o_status       (status),
        .o_result       (o_result.payload),
        .o_result_valid (o_result.valid)
    );

    assign i_cell.ready = in_ready;

endmodule
`default_nettype wire

/* tb/mcs_checker.sv */
// checker: predicts cfl signal speed results from accepted cell beats and compares
`timescale 1ns / 1ps
module mcs_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    mcs_cell_if.sink         i_cell,
    mcs_result_if.sink       i_result,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_results_seen
);
    import mcs_pkg::*;

    logic [31:0]  sweep_max;
    logic         sweep_err;
    t_result_beat sweep_results_q[$];

    function automatic logic [63:0] mag64(input logic signed [63:0] x);
        return x < 0 ? 64'(-x) : 64'(x);
    endfunction

    function automatic logic [63:0] root64(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [31:0] signal_speed(input t_cell_beat c);
        logic signed [63:0] rho, k, d, num;
        logic [63:0] arho, v, sm, sb, am, q, kmag, anum, term, rt, s;
        logic signed [31:0] mom[3];
        logic signed [31:0] fld[3];
        mom = '{c.momentum_x, c.momentum_y, c.momentum_z};
        fld = '{c.field_x, c.field_y, c.field_z};
        rho = 64'(c.density);
        arho = mag64(rho);
        v = 0; sm = 0; sb = 0;
        for (int i = 0; i < 3; i++) begin
            am = mag64(64'(mom[i]));
            q = (am << 16) / arho;
            if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
            if (q > v) v = q;
            sm = sm + am * am;
            am = mag64(64'(fld[i]));
            sb = sb + am * am;
        end
        kmag = sm / (2 * arho);
        k = rho < 0 ? -$signed(kmag) : $signed(kmag);
        d = 64'(c.energy) - k;
        if (d > (64'sd1 <<< 56)) d = 64'sd1 <<< 56;
        if (d < -(64'sd1 <<< 56)) d = -(64'sd1 <<< 56);
        num = 10 * d + 13 * $signed(sb >> 16);
        anum = mag64(num) / 9;
        if (anum > (64'd1 << 47) - 1) anum = (64'd1 << 47) - 1;
        term = (anum << 16) / arho;
        if (term > (64'd1 << 48) - 1) term = (64'd1 << 48) - 1;
        rt = root64(term << 16);
        if (rt > 64'hFFFF_FFFF) rt = 64'hFFFF_FFFF;
        s = v + rt;
        if (s > 64'hFFFF_FFFF) s = 64'hFFFF_FFFF;
        return s[31:0];
    endfunction

    assign o_pending = sweep_results_q.size();

    always @(posedge i_clk) begin
        logic [31:0]  spd;
        logic [31:0]  mx;
        logic         er;
        t_result_beat exp_beat;
        t_result_beat got;
        if (!i_rst_n) begin
            sweep_max <= '0;
            sweep_err <= 1'b0;
            o_fail_count <= 0;
            o_results_seen <= 0;
        end else begin
            if (i_cell.valid && i_cell.ready) begin
                mx = sweep_max;
                er = sweep_err;
                if (i_cell.payload.density == 0) begin
                    spd = SAT32;
                    er = 1'b1;
                end else begin
                    spd = signal_speed(i_cell.payload);
                end
                if (spd > mx) mx = spd;
                if (i_cell.payload.last_cell) begin
                    exp_beat.max_speed = mx;
                    exp_beat.divide_error = er || mx == 0;
                    if (exp_beat.divide_error) exp_beat.inverse_speed = SAT32;
                    else exp_beat.inverse_speed = ((64'd1 << 32) / mx) > 64'hFFFF_FFFF
                        ? SAT32 : 32'((64'd1 << 32) / mx);
                    sweep_results_q.push_back(exp_beat);
                    mx = 0;
                    er = 1'b0;
                end
                sweep_max <= mx;
                sweep_err <= er;
            end
            if (i_result.valid && i_result.ready) begin
                got = i_result.payload;
                o_results_seen <= o_results_seen + 1;
                if (sweep_results_q.size() == 0) begin
                    if (o_fail_count < 10) $display("unexpected result beat %p", got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_beat = sweep_results_q.pop_front();
                    if (got !== exp_beat) begin
                        if (o_fail_count < 10)
                            $display("mismatch: exp inv %h max %h err %b, got inv %h max %h err %b",
                                exp_beat.inverse_speed, exp_beat.max_speed,
                                exp_beat.divide_error, got.inverse_speed,
                                got.max_speed, got.divide_error);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

/* tb/tb_mhd_cfl_max_signal_speed.sv */
// testbench top: cell stimulus, result back-pressure and verdict
`timescale 1ns / 1ps
module tb_mhd_cfl_max_signal_speed;
    import mcs_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count, pending, results_seen;
    int   cycle_count = 0;
    int   cells_sent = 0;
    bit   hold_off = 1'b0;
    bit   stim_done = 1'b0;

    mcs_cell_if   cell_ch();
    mcs_result_if result_ch();

    always #1 i_clk = ~i_clk;

    mhd_cfl_max_signal_speed dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cell(cell_ch.sink), .o_result(result_ch.source)
    );

    mcs_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cell(cell_ch.sink), .i_result(result_ch.sink),
        .o_fail_count(fail_count), .o_pending(pending), .o_results_seen(results_seen)
    );

    initial begin
        cell_ch.valid = 1'b0;
        cell_ch.payload = '0;
        result_ch.ready = 1'b0;
    end

    function automatic int gap_len();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(20, 400) : $urandom_range(0, 3);
    endfunction

    function automatic logic [31:0] rand_field();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            2: return 32'($signed($urandom_range(0, 65535)) - 32768);
            3: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom)};
            default: return 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
        endcase
    endfunction

    // receiver: random stalls plus one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n || hold_off) result_ch.ready <= 1'b0;
        else result_ch.ready <= ($urandom_range(0, 3) != 0);
    end

    initial begin
        repeat (3000) @(posedge i_clk);
        hold_off = 1'b1;
        repeat (6000) @(posedge i_clk);
        hold_off = 1'b0;
    end

    // valid stays high only when the next beat follows without a gap
    task automatic send_cell(input t_cell_beat c);
        int g;
        g = gap_len();
        if (g != 0) begin
            cell_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        cell_ch.valid <= 1'b1;
        cell_ch.payload <= c;
        @(posedge i_clk);
        while (!cell_ch.ready) @(posedge i_clk);
        cells_sent++;
    endtask

    task automatic send_random(input bit last, input bit well);
        t_cell_beat c;
        c.density = well ? 32'($urandom_range(32'h0000_4000, 32'h0040_0000)) : rand_field();
        if (well && $urandom_range(0, 7) == 0) c.density = -c.density;
        c.momentum_x = rand_field();
        c.momentum_y = rand_field();
        c.momentum_z = rand_field();
        c.energy = rand_field();
        c.field_x = rand_field();
        c.field_y = rand_field();
        c.field_z = rand_field();
        if (!well && $urandom_range(0, 9) == 0) c.density = 0;
        c.last_cell = last;
        send_cell(c);
    endtask

    task automatic send_fixed(input logic [31:0] rho, input logic [31:0] m,
                              input logic [31:0] e, input logic [31:0] b, input bit last);
        t_cell_beat c;
        c = '{rho, m, -m, m, e, b, -b, b, last};
        send_cell(c);
    endtask

    initial begin
        int g;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // all zero fields, zero maximum
        send_fixed(32'h0001_0000, 0, 0, 0, 1'b1);
        // zero density
        send_fixed(0, 32'h0001_0000, 32'h0001_0000, 0, 1'b1);
        // extremes
        send_fixed(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_fixed(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
        send_fixed(32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b1);
        send_fixed(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1);
        // max of one raw unit
        send_fixed(32'h0001_0000, 32'h0000_0001, 0, 0, 1'b1);
        send_fixed(32'h0001_0000, 32'h0001_0000, 32'h0004_0000, 32'h0000_8000, 1'b0);
        send_fixed(32'h0002_0000, 32'hFFFF_0000, 32'hFFF0_0000, 32'h0001_0000, 1'b0);
        send_fixed(0, 0, 0, 0, 1'b0);
        send_fixed(32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 0, 1'b1);
        for (int n = 0; n < 1740; n++) begin
            bit well;
            well = $urandom_range(0, 9) != 0;
            send_random($urandom_range(0, 5) == 0, well);
        end
        send_random(1'b1, 1'b1);
        cell_ch.valid <= 1'b0;
        stim_done = 1'b1;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 4_000_000) begin
            $display("** mhd_cfl_max_signal_speed: FAILED **");
            $finish;
        end
    end

    initial begin
        wait (stim_done);
        while (pending != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
        $display("sent %0d cells incl. zero density, extremes and long back-pressure;", cells_sent);
        $display("checked %0d sweep results, %0d failures", results_seen, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("** mhd_cfl_max_signal_speed: PASSED **");
        end else begin
            $display("** mhd_cfl_max_signal_speed: FAILED **");
        end
        $finish;
    end
endmodule
